/* rtl/csn_pkg.sv */
// Package for the cone surface normal block: transfer types, fixed-point widths,
// region codes and register indexes. It has no dependencies.
package csn_pkg;

   localparam int CoordWidth = 32;
   localparam int FracBits   = 16;
   localparam int TolWidth   = 16;
   localparam int RadWidth   = 2 * CoordWidth;
   localparam int RemWidth   = CoordWidth + 2;
   localparam int CsrAddrWidth = 2;

   localparam logic [1:0] REGION_SIDE   = 2'd0;
   localparam logic [1:0] REGION_TOP    = 2'd1;
   localparam logic [1:0] REGION_BOTTOM = 2'd2;

   localparam logic [CsrAddrWidth-1:0] REG_CONE_MIN  = 2'd0;
   localparam logic [CsrAddrWidth-1:0] REG_CONE_MAX  = 2'd1;
   localparam logic [CsrAddrWidth-1:0] REG_TOLERANCE = 2'd2;

   typedef struct packed {
      logic signed [CoordWidth-1:0] px;
      logic signed [CoordWidth-1:0] py;
      logic signed [CoordWidth-1:0] pz;
   } req_type;

   typedef struct packed {
      logic signed [CoordWidth-1:0] nx;
      logic signed [CoordWidth-1:0] ny;
      logic signed [CoordWidth-1:0] nz;
      logic [1:0]                   region;
   } rsp_type;

   typedef struct packed {
      logic [RemWidth-1:0]   rem;
      logic [CoordWidth-1:0] root;
      logic [RadWidth-1:0]   rad;
   } root_step_type;

   typedef struct packed {
      logic signed [CoordWidth-1:0] x;
      logic signed [CoordWidth-1:0] z;
      logic                         y_pos;
      logic [1:0]                   region;
   } side_type;

endpackage

/* rtl/csn_root_cell.sv */
// One cell of the square root chain: settles one root bit per stage and passes the
// point's side data along. Depends on csn_pkg.
module csn_root_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  csn_pkg::root_step_type in_step,
   input  csn_pkg::side_type      in_side,
   output logic                   out_valid,
   output csn_pkg::root_step_type out_step,
   output csn_pkg::side_type      out_side
);
   import csn_pkg::*;

   logic          valid_ff, valid_in;
   root_step_type step_ff, step_in;
   side_type      side_ff;
   logic [RemWidth-1:0] rem_shift, trial;

   assign rem_shift = {in_step.rem[CoordWidth-1:0], in_step.rad[RadWidth-1 -: 2]};
   assign trial     = {in_step.root, 2'b01};
   assign valid_in  = in_valid;

   always_comb begin
      step_in.rad = {in_step.rad[RadWidth-3:0], 2'b00};
      if (rem_shift >= trial) begin
         step_in.rem  = rem_shift - trial;
         step_in.root = {in_step.root[CoordWidth-2:0], 1'b1};
      end else begin
         step_in.rem  = rem_shift;
         step_in.root = {in_step.root[CoordWidth-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      side_ff <= in_side;
   end

   assign out_valid = valid_ff;
   assign out_step  = step_ff;
   assign out_side  = side_ff;

endmodule

/* rtl/cone_surface_normal.sv */
// Top level of the cone surface normal block: cap tests, squares and a chain of
// square root cells. Depends on csn_pkg and csn_root_cell.
//
//   port group   direction  transfer
//   req_*        in         point px, py, pz; taken when start is high and busy low
//   rsp_*        out        normal nx, ny, nz and region; one cycle under rsp_valid
//   csr_*        in         register write; taken when csr_we is high
//
// A point can be taken every cycle while busy is low. Its result passes through
// three front stages (input, squares, cap test) and one stage for each of the 32
// cells of the root chain, then the output register. Busy is high during reset and
// in the first cycle after it. The receiver cannot stall, so the pipeline never holds.
module cone_surface_normal (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  csn_pkg::req_type                    req,
   output logic                                rsp_valid,
   output csn_pkg::rsp_type                    rsp,
   input  logic                                csr_we,
   input  logic [csn_pkg::CsrAddrWidth-1:0]    csr_addr,
   input  logic [csn_pkg::CoordWidth-1:0]      csr_wdata
);
   import csn_pkg::*;

   localparam logic [CoordWidth-1:0] One    = CoordWidth'(1) << FracBits;
   localparam logic [CoordWidth-1:0] MaxPos = {1'b0, {(CoordWidth-1){1'b1}}};

   logic busy_ff;

   logic signed [CoordWidth-1:0] cone_min_ff, cone_max_ff;
   logic [TolWidth-1:0]          tol_ff;
   logic [RadWidth:0]            top_lim_ff, bot_lim_ff;
   logic [CoordWidth-1:0]        mag_min, mag_max;
   logic [RadWidth:0]            eps_wide;

   logic    s1_valid_ff;
   req_type s1_ff;
   logic [CoordWidth-1:0] mag_x, mag_z;
   logic signed [CoordWidth:0] py_ext, top_h, bot_h, tol_ext;

   logic                 s2_valid_ff;
   logic [RadWidth-1:0]  sqx_ff, sqz_ff;
   logic                 top_h_ff, bot_h_ff, y_pos2_ff;
   logic signed [CoordWidth-1:0] x2_ff, z2_ff;

   logic [RadWidth-1:0] rad_sum;
   logic                s3_valid_ff;
   root_step_type       s3_step_ff;
   side_type            s3_side_ff;
   logic [1:0]          region_in;

   logic          chain_valid [CoordWidth+1];
   root_step_type chain_step  [CoordWidth+1];
   side_type      chain_side  [CoordWidth+1];

   logic            rsp_valid_ff;
   rsp_type         rsp_ff, rsp_in;
   logic [CoordWidth-1:0] root_sat;
   side_type        last_side;

   // Configuration registers and the cap limits derived from them.
   always_ff @(posedge clock) begin
      if (reset) begin
         cone_min_ff <= '0;
         cone_max_ff <= CoordWidth'(65536);
         tol_ff      <= TolWidth'(1);
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_CONE_MIN:  cone_min_ff <= csr_wdata;
            REG_CONE_MAX:  cone_max_ff <= csr_wdata;
            REG_TOLERANCE: tol_ff      <= csr_wdata[TolWidth-1:0];
            default: ;
         endcase
      end
   end

   assign mag_min  = cone_min_ff[CoordWidth-1] ? (~cone_min_ff + 1'b1) : cone_min_ff;
   assign mag_max  = cone_max_ff[CoordWidth-1] ? (~cone_max_ff + 1'b1) : cone_max_ff;
   assign eps_wide = {{(RadWidth+1-TolWidth-FracBits){1'b0}}, tol_ff, {FracBits{1'b0}}};

   always_ff @(posedge clock) begin
      top_lim_ff <= {1'b0, RadWidth'(mag_max) * RadWidth'(mag_max)} + eps_wide;
      bot_lim_ff <= {1'b0, RadWidth'(mag_min) * RadWidth'(mag_min)} + eps_wide;
   end

   // Control registers of the front stages and the output.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         s1_valid_ff  <= start && !busy_ff;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= chain_valid[CoordWidth];
      end
   end

   // Stage 1: input register.
   always_ff @(posedge clock) begin
      s1_ff <= req;
   end

   // Stage 2: squares and height tests.
   assign mag_x   = s1_ff.px[CoordWidth-1] ? (~s1_ff.px + 1'b1) : s1_ff.px;
   assign mag_z   = s1_ff.pz[CoordWidth-1] ? (~s1_ff.pz + 1'b1) : s1_ff.pz;
   assign py_ext  = {s1_ff.py[CoordWidth-1], s1_ff.py};
   assign tol_ext = {{(CoordWidth+1-TolWidth){1'b0}}, tol_ff};
   assign top_h   = {cone_max_ff[CoordWidth-1], cone_max_ff} - tol_ext;
   assign bot_h   = {cone_min_ff[CoordWidth-1], cone_min_ff} + tol_ext;

   always_ff @(posedge clock) begin
      sqx_ff    <= RadWidth'(mag_x) * RadWidth'(mag_x);
      sqz_ff    <= RadWidth'(mag_z) * RadWidth'(mag_z);
      top_h_ff  <= py_ext >= top_h;
      bot_h_ff  <= py_ext <= bot_h;
      y_pos2_ff <= !s1_ff.py[CoordWidth-1] && (s1_ff.py != '0);
      x2_ff     <= s1_ff.px;
      z2_ff     <= s1_ff.pz;
   end

   // Stage 3: squared distance and cap tests.
   assign rad_sum = sqx_ff + sqz_ff;

   always_comb begin
      priority if (top_h_ff && ({1'b0, rad_sum} <= top_lim_ff)) begin
         region_in = REGION_TOP;
      end else if (bot_h_ff && ({1'b0, rad_sum} <= bot_lim_ff)) begin
         region_in = REGION_BOTTOM;
      end else begin
         region_in = REGION_SIDE;
      end
   end

   always_ff @(posedge clock) begin
      s3_step_ff.rem    <= '0;
      s3_step_ff.root   <= '0;
      s3_step_ff.rad    <= rad_sum;
      s3_side_ff.x      <= x2_ff;
      s3_side_ff.z      <= z2_ff;
      s3_side_ff.y_pos  <= y_pos2_ff;
      s3_side_ff.region <= region_in;
   end

   // Root chain: one cell per root bit.
   assign chain_valid[0] = s3_valid_ff;
   assign chain_step[0]  = s3_step_ff;
   assign chain_side[0]  = s3_side_ff;

   for (genvar i = 0; i < CoordWidth; i++) begin : g_cell
      csn_root_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_step   (chain_step[i]),
         .in_side   (chain_side[i]),
         .out_valid (chain_valid[i+1]),
         .out_step  (chain_step[i+1]),
         .out_side  (chain_side[i+1])
      );
   end

   // Output: cap normals, or the side normal with a saturated, signed root.
   assign last_side = chain_side[CoordWidth];
   assign root_sat  = chain_step[CoordWidth].root[CoordWidth-1] ?
                      MaxPos : chain_step[CoordWidth].root;

   always_comb begin
      rsp_in.region = last_side.region;
      unique case (last_side.region)
         REGION_TOP: begin
            rsp_in.nx = '0;
            rsp_in.ny = One;
            rsp_in.nz = '0;
         end
         REGION_BOTTOM: begin
            rsp_in.nx = '0;
            rsp_in.ny = ~One + 1'b1;
            rsp_in.nz = '0;
         end
         default: begin
            rsp_in.nx = last_side.x;
            rsp_in.ny = last_side.y_pos ? (~root_sat + 1'b1) : root_sat;
            rsp_in.nz = last_side.z;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

/* bench/tb_cone_surface_normal.sv */
`timescale 1ns / 100ps
// Self-checking testbench for cone_surface_normal: sends points on the command port,
// predicts every normal in the bench and checks each result transfer in order.
// Depends on csn_pkg and the cone_surface_normal RTL.
module tb_cone_surface_normal;
   import csn_pkg::*;

   localparam int PipeLatency = 35;
   localparam int CycleLimit  = 200000;
   localparam int ReportLimit = 10;
   localparam logic [CsrAddrWidth-1:0] REG_UNUSED = 2'd3;
   localparam longint MaxCode = (longint'(1) << (CoordWidth - 1)) - 1;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   req_type                 req;
   logic                    rsp_valid;
   rsp_type                 rsp;
   logic                    csr_we;
   logic [CsrAddrWidth-1:0] csr_addr;
   logic [CoordWidth-1:0]   csr_wdata;

   longint              height_lo = 0;
   longint              height_hi = longint'(1) << FracBits;
   logic [TolWidth-1:0] eps_raw = 1;
   rsp_type             normal_q[$];
   int                  error_count = 0;
   int                  cycle_count = 0;
   int                  gap_pct = 10;

   cone_surface_normal i_dut (
      .clock,
      .reset,
      .start,
      .busy,
      .req,
      .rsp_valid,
      .rsp,
      .csr_we,
      .csr_addr,
      .csr_wdata
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic void note_error(input string msg);
      if (error_count < ReportLimit) begin
         $display("ERROR at cycle %0d: %s", cycle_count, msg);
      end
      error_count++;
   endfunction

   function automatic logic [64:0] square_mag(input longint v);
      logic [64:0] m;
      m = (v < 0) ? 65'(-v) : 65'(v);
      return m * m;
   endfunction

   function automatic rsp_type predict_normal(input req_type p);
      longint      x;
      longint      y;
      longint      z;
      logic [64:0] rad_sum;
      logic [64:0] eps_sq;
      logic [65:0] root;
      logic [65:0] trial;
      rsp_type     n;
      x = p.px;
      y = p.py;
      z = p.pz;
      rad_sum = square_mag(x) + square_mag(z);
      eps_sq = 65'(eps_raw) << FracBits;
      n = '0;
      if (y >= height_hi - longint'(eps_raw) && rad_sum <= square_mag(height_hi) + eps_sq) begin
         n.ny = 1 << FracBits;
         n.region = REGION_TOP;
      end else if (y <= height_lo + longint'(eps_raw) &&
                   rad_sum <= square_mag(height_lo) + eps_sq) begin
         n.ny = -(1 << FracBits);
         n.region = REGION_BOTTOM;
      end else begin
         root = '0;
         for (int b = CoordWidth - 1; b >= 0; b--) begin
            trial = root | (66'd1 << b);
            if (trial * trial <= {1'b0, rad_sum}) root = trial;
         end
         if (root > 66'(MaxCode)) root = 66'(MaxCode);
         n.nx = p.px;
         n.nz = p.pz;
         n.ny = (y > 0) ? -root[CoordWidth-1:0] : root[CoordWidth-1:0];
         n.region = REGION_SIDE;
      end
      return n;
   endfunction

   always @(posedge clock) begin : check_normals
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (normal_q.size() == 0) begin
            note_error($sformatf("unexpected result nx=%h ny=%h nz=%h region=%0d",
                                 rsp.nx, rsp.ny, rsp.nz, rsp.region));
         end else begin
            want = normal_q.pop_front();
            if (rsp.nx !== want.nx || rsp.ny !== want.ny || rsp.nz !== want.nz ||
                rsp.region !== want.region) begin
               note_error($sformatf({"expected nx=%h ny=%h nz=%h region=%0d, ",
                                     "got nx=%h ny=%h nz=%h region=%0d"},
                                    want.nx, want.ny, want.nz, want.region,
                                    rsp.nx, rsp.ny, rsp.nz, rsp.region));
            end
         end
      end
   end

   function automatic req_type make_req(input logic [CoordWidth-1:0] x,
                                        input logic [CoordWidth-1:0] y,
                                        input logic [CoordWidth-1:0] z);
      req_type p;
      p.px = x;
      p.py = y;
      p.pz = z;
      return p;
   endfunction

   task automatic send_point(input req_type p);
      while ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req <= p;
      @(posedge clock);
      while (busy) @(posedge clock);
      normal_q.push_back(predict_normal(p));
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (normal_q.size() != 0) @(posedge clock);
      repeat (PipeLatency + 5) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrAddrWidth-1:0] addr,
                            input logic [CoordWidth-1:0] data);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (addr)
         REG_CONE_MIN:  height_lo = signed'(data);
         REG_CONE_MAX:  height_hi = signed'(data);
         REG_TOLERANCE: eps_raw = data[TolWidth-1:0];
         default: ;
      endcase
   endtask

   task automatic set_heights(input logic [CoordWidth-1:0] lo,
                              input logic [CoordWidth-1:0] hi,
                              input logic [TolWidth-1:0] tol);
      wait_drained();
      write_reg(REG_CONE_MIN, lo);
      write_reg(REG_CONE_MAX, hi);
      write_reg(REG_TOLERANCE, 32'(tol));
   endtask

   function automatic req_type make_point();
      req_type p;
      longint  h;
      longint  rad;
      longint  a;
      longint  b;
      int      kind;
      kind = $urandom_range(9);
      p = make_req($urandom, $urandom, $urandom);
      if (kind >= 2 && kind <= 7) begin
         h = (kind <= 4) ? height_hi : height_lo;
         rad = (h < 0) ? -h : h;
         if ($urandom_range(1)) a = rad + int'($urandom_range(8)) - 4;
         else a = longint'({$urandom, $urandom} % (rad + 1));
         if ($urandom_range(1)) a = -a;
         b = int'($urandom_range(6)) - 3;
         if ($urandom_range(1)) begin
            p.px = CoordWidth'(a);
            p.pz = CoordWidth'(b);
         end else begin
            p.px = CoordWidth'(b);
            p.pz = CoordWidth'(a);
         end
         p.py = CoordWidth'(h + int'($urandom_range(2 * eps_raw + 8)) -
                            longint'(eps_raw) - 4);
      end else if (kind >= 8) begin
         p.px = $signed($urandom) >>> $urandom_range(24);
         p.py = $signed($urandom) >>> $urandom_range(20);
         p.pz = $signed($urandom) >>> $urandom_range(24);
      end
      return p;
   endfunction

   task automatic pick_heights(input int mode);
      logic [CoordWidth-1:0] lo;
      logic [CoordWidth-1:0] hi;
      logic [TolWidth-1:0]   tol;
      case (mode)
         0: begin
            lo = 32'h8000_0000;
            hi = 32'h7FFF_FFFF;
            tol = 16'hFFFF;
         end
         1: begin
            lo = 32'h7FFF_FFFF;
            hi = 32'h8000_0000;
            tol = '0;
         end
         2: begin
            lo = $urandom;
            hi = $urandom;
            tol = TolWidth'($urandom);
         end
         default: begin
            lo = int'($urandom_range(16 << FracBits)) - (8 << FracBits);
            hi = lo + $urandom_range(8 << FracBits);
            tol = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(255));
         end
      endcase
      set_heights(lo, hi, tol);
   endtask

   task automatic test_reset_values();
      send_point(make_req(32'd0, 32'h0001_0000, 32'd0));
      send_point(make_req(32'd0, 32'd0, 32'd0));
      send_point(make_req(32'h0001_0000, 32'h0000_8000, 32'd0));
      send_point(make_req(32'h0003_0000, 32'd0, 32'd0));
      send_point(make_req(32'd0, 32'hFFFB_0000, 32'h0004_0000));
   endtask

   task automatic test_cap_edges();
      send_point(make_req(32'h0001_0000, 32'h0000_FFFF, 32'd0));
      send_point(make_req(32'h0001_0001, 32'h0000_FFFF, 32'd0));
   endtask

   task automatic test_field_extremes();
      send_point(make_req(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
      send_point(make_req(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
      send_point(make_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_point(make_req(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_5555));
   endtask

   task automatic test_register_extremes();
      set_heights(32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
      send_point(make_req(32'd0, 32'h7FFF_0000, 32'd0));
      send_point(make_req(32'd0, 32'h7FFE_FFFF, 32'd0));
      send_point(make_req(32'd5, 32'h8000_0000, 32'd7));
      set_heights(32'h8000_0000, 32'h7FFF_FFFF, 16'h0000);
      send_point(make_req(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0));
      send_point(make_req(32'h8000_0000, 32'h7FFF_FFFF, 32'd0));
   endtask

   task automatic test_inverted_heights();
      set_heights(32'h0005_0000, 32'hFFFB_0000, 16'd1);
      send_point(make_req(32'd0, 32'd0, 32'd0));
      send_point(make_req(32'd0, 32'hFFF6_0000, 32'd0));
      send_point(make_req(32'h000A_0000, 32'd0, 32'd0));
   endtask

   task automatic test_unknown_index();
      wait_drained();
      write_reg(REG_UNUSED, 32'hFFFF_FFFF);
      send_point(make_req(32'd0, 32'd0, 32'd0));
      send_point(make_req(32'h0001_0000, 32'hFFF6_0000, 32'h0002_0000));
   endtask

   task automatic test_random_points(input int phase, input int idle_pct);
      wait_drained();
      gap_pct = idle_pct;
      for (int k = 0; k < 4; k++) begin
         pick_heights((k == 0) ? phase : ((k == 1) ? 2 : 3));
         repeat (105) send_point(make_point());
      end
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req <= '0;
      csr_we <= 1'b0;
      csr_addr <= '0;
      csr_wdata <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_cap_edges();
      test_field_extremes();
      test_register_extremes();
      test_inverted_heights();
      test_unknown_index();
      test_random_points(0, 10);
      test_random_points(1, 75);
      test_random_points(2, 0);
      wait_drained();
      if (error_count == 0 && normal_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/csn_pkg.sv
rtl/csn_root_cell.sv
rtl/cone_surface_normal.sv
bench/tb_cone_surface_normal.sv
